// ===== rtl/gbvs_pkg.sv =====
// ---------------------------------------------------------------------------
// Ground brake velocity step package
// Shared constants and the side-band type that runs beside the root pipeline.
// ---------------------------------------------------------------------------
package gbvs_pkg;

  localparam int SQRT_STAGES = 31;
  localparam int SIDE_LEN    = SQRT_STAGES - 1;
  localparam int NUM_STAGES  = SQRT_STAGES + 4;

  localparam logic [30:0] THR_FLOOR   = 31'h0000a000;
  localparam logic [30:0] MAG_MAX     = 31'h7fffffff;
  localparam logic [32:0] INCLINE_MIN = 33'sh000000300;
  localparam logic [32:0] UNIT_Q12    = 33'sh000001000;
  localparam logic [21:0] RECIP_13    = 22'd2581111;

  typedef struct packed {
    logic signed [31:0] v_x;
    logic signed [31:0] v_y;
    logic signed [31:0] v_z;
    logic signed [31:0] nv_x;
    logic signed [31:0] nv_y;
    logic signed [31:0] nv_z;
    logic signed [31:0] given;
    logic               allow;
    logic [7:0]         mstate;
    logic [30:0]        thr;
    logic               cap;
  } side_t;

endpackage

// ===== rtl/ground_brake_velocity_step.sv =====
// ---------------------------------------------------------------------------
// Ground brake velocity step
// Brakes or stops a body on the ground from its velocity and the slope.
// ---------------------------------------------------------------------------
// Throughput is one word per cycle while the output is not stalled; the
// 31-stage square root pipeline sets the depth, and a stalled output holds
// every stage in place.
// Reset (rst_n low, synchronous) clears all stage valid bits.
// ---------------------------------------------------------------------------
module ground_brake_velocity_step (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vel_x_in, vel_y_in, vel_z_in, given_magnitude, slope_normal_y,
  // brake_enable, motion_state, brake_strength, frame_scale, zero pad.
  input  logic [239:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // vel_x_out, vel_y_out, vel_z_out, magnitude_out, speed_value,
  // brake_limit, decelerated, stopped, state_change_request.
  output logic [191:0] out_tdata
);

  logic en;
  logic valid_r [gbvs_pkg::NUM_STAGES];

  assign en         = !valid_r[gbvs_pkg::NUM_STAGES-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = valid_r[gbvs_pkg::NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gbvs_pkg::NUM_STAGES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (en) begin
      valid_r[0] <= in_tvalid;
      for (int i = 1; i < gbvs_pkg::NUM_STAGES; i++) begin
        valid_r[i] <= valid_r[i-1];
      end
    end
  end

  logic signed [31:0] in_v [3];
  assign in_v[0] = in_tdata[31:0];
  assign in_v[1] = in_tdata[63:32];
  assign in_v[2] = in_tdata[95:64];

  // Stage 1: capture and absolute values.
  logic signed [31:0] p1_v_r [3];
  logic [31:0]        p1_a_r [3];
  logic signed [31:0] p1_given_r, p1_slope_r, p1_strength_r, p1_fscale_r;
  logic               p1_allow_r;
  logic [7:0]         p1_mstate_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_v_r[i] <= in_v[i];
        p1_a_r[i] <= in_v[i][31] ? 32'(-in_v[i]) : in_v[i];
      end
      p1_given_r    <= in_tdata[127:96];
      p1_slope_r    <= in_tdata[159:128];
      p1_allow_r    <= in_tdata[160];
      p1_mstate_r   <= in_tdata[168:161];
      p1_strength_r <= in_tdata[200:169];
      p1_fscale_r   <= in_tdata[232:201];
    end
  end

  // Stage 2: squares, brake products and threshold numerator.
  logic signed [32:0] s1_neg, s1_incl, s1_d;
  logic signed [27:0] s1_factor;

  always_comb begin
    s1_neg  = -{p1_slope_r[31], p1_slope_r};
    s1_incl = (s1_neg > 33'sh07fffffff) ? 33'sh07fffffff : s1_neg;
    if (s1_incl < $signed(gbvs_pkg::INCLINE_MIN)) begin
      s1_incl = gbvs_pkg::INCLINE_MIN;
    end
    s1_d      = $signed(gbvs_pkg::UNIT_Q12) - s1_incl;
    s1_factor = p1_strength_r[31:4];
  end

  logic signed [31:0] p2_v_r [3];
  logic [63:0]        p2_sq_r [3];
  logic signed [59:0] p2_prod_r [3];
  logic               p2_def_r, p2_dpos_r;
  logic [20:0]        p2_x_r;
  logic signed [31:0] p2_given_r, p2_fscale_r;
  logic               p2_allow_r;
  logic [7:0]         p2_mstate_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p2_v_r[i]    <= p1_v_r[i];
        p2_sq_r[i]   <= {32'd0, p1_a_r[i]} * {32'd0, p1_a_r[i]};
        p2_prod_r[i] <= 60'(p1_v_r[i] * s1_factor);
      end
      p2_def_r    <= (p1_strength_r < 32'sd1);
      p2_dpos_r   <= (s1_d > 33'sd0);
      p2_x_r      <= {s1_d[11:0], 9'd0} - {2'b00, s1_d[11:0], 7'd0};
      p2_given_r  <= p1_given_r;
      p2_fscale_r <= p1_fscale_r;
      p2_allow_r  <= p1_allow_r;
      p2_mstate_r <= p1_mstate_r;
    end
  end

  // Stage 3: sum of squares, brake terms, threshold quotient.
  logic signed [59:0] s2_tz   [3];
  logic signed [52:0] s2_q    [3];
  logic signed [31:0] s2_term [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_tz[i] = p2_prod_r[i][59] ? p2_prod_r[i] + 60'sd127 : p2_prod_r[i];
      s2_q[i]  = 53'(s2_tz[i] >>> 7);
      if (p2_def_r) begin
        s2_term[i] = p2_v_r[i] >>> 4;
      end else if (s2_q[i] > 53'sh0007fffffff) begin
        s2_term[i] = 32'sh7fffffff;
      end else if (s2_q[i] < -53'sh00080000000) begin
        s2_term[i] = 32'sh80000000;
      end else begin
        s2_term[i] = s2_q[i][31:0];
      end
    end
  end

  logic signed [31:0] p3_v_r [3];
  logic signed [31:0] p3_term_r [3];
  logic [63:0]        p3_sum_r;
  logic [42:0]        p3_qprod_r;
  logic               p3_dpos_r;
  logic signed [31:0] p3_given_r, p3_fscale_r;
  logic               p3_allow_r;
  logic [7:0]         p3_mstate_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p3_v_r[i]    <= p2_v_r[i];
        p3_term_r[i] <= s2_term[i];
      end
      p3_sum_r    <= p2_sq_r[0] + p2_sq_r[1] + p2_sq_r[2];
      p3_qprod_r  <= {22'd0, p2_x_r} * {21'd0, gbvs_pkg::RECIP_13};
      p3_dpos_r   <= p2_dpos_r;
      p3_given_r  <= p2_given_r;
      p3_fscale_r <= p2_fscale_r;
      p3_allow_r  <= p2_allow_r;
      p3_mstate_r <= p2_mstate_r;
    end
  end

  // Stage 4: scaled brake terms, threshold floor, root start.
  logic [17:0] s3_qv;
  assign s3_qv = p3_qprod_r[42:25];

  logic signed [31:0] p4_v_r [3];
  logic signed [63:0] p4_sprod_r [3];
  logic [30:0]        p4_thr_r;
  logic               p4_cap_r;
  logic signed [31:0] p4_given_r;
  logic               p4_allow_r;
  logic [7:0]         p4_mstate_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p4_v_r[i]     <= p3_v_r[i];
        p4_sprod_r[i] <= p3_term_r[i] * p3_fscale_r;
      end
      if (!p3_dpos_r || {13'd0, s3_qv} < gbvs_pkg::THR_FLOOR) begin
        p4_thr_r <= gbvs_pkg::THR_FLOOR;
      end else begin
        p4_thr_r <= {13'd0, s3_qv};
      end
      p4_cap_r    <= (p3_sum_r[63:62] != 2'b00);
      p4_given_r  <= p3_given_r;
      p4_allow_r  <= p3_allow_r;
      p4_mstate_r <= p3_mstate_r;
    end
  end

  logic [30:0] root;

  gbvs_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .t_in (p3_sum_r[61:0]),
    .root (root)
  );

  // Stage 5: decelerated velocity, then side data waits for the root.
  logic signed [64:0] s4_diff [3];
  logic signed [31:0] s4_nv   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_diff[i] = {{33{p4_v_r[i][31]}}, p4_v_r[i]}
                   - {{9{p4_sprod_r[i][63]}}, p4_sprod_r[i][63:8]};
      if (s4_diff[i] > 65'sh00000000_7fffffff) begin
        s4_nv[i] = 32'sh7fffffff;
      end else if (s4_diff[i] < -65'sh00000000_80000000) begin
        s4_nv[i] = 32'sh80000000;
      end else begin
        s4_nv[i] = s4_diff[i][31:0];
      end
    end
  end

  gbvs_pkg::side_t side_r [gbvs_pkg::SIDE_LEN];

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0].v_x    <= p4_v_r[0];
      side_r[0].v_y    <= p4_v_r[1];
      side_r[0].v_z    <= p4_v_r[2];
      side_r[0].nv_x   <= s4_nv[0];
      side_r[0].nv_y   <= s4_nv[1];
      side_r[0].nv_z   <= s4_nv[2];
      side_r[0].given  <= p4_given_r;
      side_r[0].allow  <= p4_allow_r;
      side_r[0].mstate <= p4_mstate_r;
      side_r[0].thr    <= p4_thr_r;
      side_r[0].cap    <= p4_cap_r;
      for (int i = 1; i < gbvs_pkg::SIDE_LEN; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // Output stage: magnitude, speed and the brake decision.
  gbvs_pkg::side_t sd;
  logic [30:0]        f_mag, f_speed;
  logic               f_brake, f_dec, f_stp;
  logic signed [31:0] f_vx, f_vy, f_vz;

  always_comb begin
    sd = side_r[gbvs_pkg::SIDE_LEN-1];
    if (!sd.given[31]) begin
      f_mag = sd.given[30:0];
    end else if (sd.cap) begin
      f_mag = gbvs_pkg::MAG_MAX;
    end else begin
      f_mag = root;
    end
    f_speed = (f_mag[30:25] != 6'd0) ? gbvs_pkg::MAG_MAX : {f_mag[24:0], 6'd0};
    f_brake = sd.allow && (sd.mstate == 8'd0);
    f_dec   = f_brake && (sd.thr < f_speed);
    f_stp   = f_brake && !f_dec && (sd.thr == gbvs_pkg::THR_FLOOR);
    if (f_dec) begin
      f_vx = sd.nv_x;
      f_vy = sd.nv_y;
      f_vz = sd.nv_z;
    end else if (f_stp) begin
      f_vx = '0;
      f_vy = '0;
      f_vz = '0;
    end else begin
      f_vx = sd.v_x;
      f_vy = sd.v_y;
      f_vz = sd.v_z;
    end
  end

  logic [191:0] out_data_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {f_stp, f_stp, f_dec, sd.thr, f_speed, f_mag, f_vz, f_vy, f_vx};
    end
  end

  assign out_tdata = out_data_r;

endmodule

// ===== rtl/gbvs_sqrt.sv =====
// ---------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 62-bit value, one result bit per register stage.
// ---------------------------------------------------------------------------
module gbvs_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [61:0] t_in,
  output logic [30:0] root
);

  logic [63:0] rem_r  [gbvs_pkg::SQRT_STAGES];
  logic [30:0] root_r [gbvs_pkg::SQRT_STAGES];

  genvar s;
  generate
    for (s = 0; s < gbvs_pkg::SQRT_STAGES; s++) begin : g_stage
      localparam int J = gbvs_pkg::SQRT_STAGES - 1 - s;
      logic [63:0] rem_prev;
      logic [30:0] root_prev;
      logic [63:0] trial;

      if (s == 0) begin : g_first
        assign rem_prev  = {2'b00, t_in};
        assign root_prev = '0;
      end else begin : g_next
        assign rem_prev  = rem_r[s-1];
        assign root_prev = root_r[s-1];
      end

      assign trial = ({33'd0, root_prev} << (J + 1)) | (64'd1 << (2 * J));

      always_ff @(posedge clk) begin
        if (en) begin
          if (rem_prev >= trial) begin
            rem_r[s]  <= rem_prev - trial;
            root_r[s] <= root_prev | (31'd1 << J);
          end else begin
            rem_r[s]  <= rem_prev;
            root_r[s] <= root_prev;
          end
        end
      end
    end
  endgenerate

  assign root = root_r[gbvs_pkg::SQRT_STAGES-1];

endmodule

// ===== verif/ground_brake_velocity_step_test.sv =====
// ---------------------------------------------------------------------------
// Ground brake velocity step testbench
// Drives directed and random velocity words through the stream input with
// random idling on both sides, predicts each result word in the bench and
// compares every accepted output word field by field, in order.
// ---------------------------------------------------------------------------
module ground_brake_velocity_step_test;

  typedef struct {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] given;
    logic signed [31:0] slope;
    logic               allow;
    logic [7:0]         mstate;
    logic signed [31:0] strength;
    logic signed [31:0] fscale;
  } body_t;

  typedef struct {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [30:0]        mag;
    logic [30:0]        speed;
    logic [30:0]        thr;
    logic               dec;
    logic               stp;
    logic               req;
  } step_t;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [239:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b1;
  logic [191:0] out_tdata;

  step_t pending_steps[$];
  int    fail_count = 0;
  bit    quiet = 1'b0;

  ground_brake_velocity_step u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  function automatic longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint floor_root(logic [65:0] sum);
    longint unsigned t;
    longint unsigned res;
    longint unsigned b;
    if (sum >= 66'h1 << 62) return S32_MAX;
    t = sum[63:0];
    res = 0;
    b = 64'h1 << 62;
    while (b > t) b = b >> 2;
    while (b != 0) begin
      if (t >= res + b) begin
        t = t - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint decel_term(longint v, longint strength);
    longint prod;
    if (strength < 1) return clamp32(v >>> 4);
    prod = v * (strength >>> 4);
    if (prod < 0) prod = prod + 64'sd127;
    return clamp32(prod >>> 7);
  endfunction

  function automatic step_t predict_brake(body_t b);
    step_t       r;
    longint      v[3];
    longint      a;
    logic [65:0] sum;
    longint      mag;
    longint      speed;
    longint      incline;
    longint      thr;
    longint      term;
    v[0] = longint'(b.vx);
    v[1] = longint'(b.vy);
    v[2] = longint'(b.vz);
    r.dec = 1'b0;
    r.stp = 1'b0;
    r.req = 1'b0;
    if (b.given >= 0) begin
      mag = longint'(b.given);
    end else begin
      sum = '0;
      for (int i = 0; i < 3; i++) begin
        a = (v[i] < 0) ? -v[i] : v[i];
        sum = sum + {2'b00, 64'(a * a)};
      end
      mag = floor_root(sum);
    end
    speed = mag * 64;
    if (speed > S32_MAX) speed = S32_MAX;
    incline = clamp32(-longint'(b.slope));
    if (incline < 64'sh300) incline = 64'sh300;
    thr = ((64'sh1000 - incline) * 64'sh1800) / 64'shd0;
    if (thr < 64'sha000) thr = 64'sha000;
    if (b.allow && b.mstate == 8'h00) begin
      if (thr < speed) begin
        for (int i = 0; i < 3; i++) begin
          term = decel_term(v[i], longint'(b.strength));
          v[i] = clamp32(v[i] - ((term * longint'(b.fscale)) >>> 8));
        end
        r.dec = 1'b1;
      end else if (thr == 64'sha000) begin
        v[0] = 0;
        v[1] = 0;
        v[2] = 0;
        r.stp = 1'b1;
        r.req = 1'b1;
      end
    end
    r.vx = v[0][31:0];
    r.vy = v[1][31:0];
    r.vz = v[2][31:0];
    r.mag = mag[30:0];
    r.speed = speed[30:0];
    r.thr = thr[30:0];
    return r;
  endfunction

  task automatic send_body(body_t b);
    while (!quiet && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, b.fscale, b.strength, b.mstate, b.allow, b.slope, b.given,
                 b.vz, b.vy, b.vx};
    do @(posedge clk); while (!in_tready);
    pending_steps.push_back(predict_brake(b));
  endtask

  task automatic idle_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 8);
  end

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    step_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_steps.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, out_tdata);
        fail_count++;
      end else begin
        e = pending_steps.pop_front();
        check_field("vel_x", e.vx, out_tdata[31:0]);
        check_field("vel_y", e.vy, out_tdata[63:32]);
        check_field("vel_z", e.vz, out_tdata[95:64]);
        check_field("magnitude", {1'b0, e.mag}, {1'b0, out_tdata[126:96]});
        check_field("speed", {1'b0, e.speed}, {1'b0, out_tdata[157:127]});
        check_field("threshold", {1'b0, e.thr}, {1'b0, out_tdata[188:158]});
        check_field("decelerated", {31'b0, e.dec}, {31'b0, out_tdata[189]});
        check_field("stopped", {31'b0, e.stp}, {31'b0, out_tdata[190]});
        check_field("state_request", {31'b0, e.req}, {31'b0, out_tdata[191]});
      end
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(4096) - 2048;
      3: return $urandom_range(200000) - 100000;
      default: return $urandom;
    endcase
  endfunction

  function automatic body_t random_body();
    body_t b;
    b.vx = pick_word();
    b.vy = pick_word();
    b.vz = pick_word();
    case ($urandom_range(3))
      0: b.given = pick_word();
      1: b.given = $urandom_range(3000);
      default: b.given = -$urandom_range(1, 5);
    endcase
    b.slope = ($urandom_range(1)) ? pick_word() : -$urandom_range(4200);
    b.allow = ($urandom_range(9) != 0);
    b.mstate = ($urandom_range(9) == 0) ? 8'($urandom) : 8'h00;
    b.strength = ($urandom_range(2) == 0) ? -$urandom_range(3) : pick_word();
    b.fscale = ($urandom_range(1)) ? $urandom_range(512) : pick_word();
    return b;
  endfunction

  function automatic body_t make_body(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                      logic [31:0] given, logic [31:0] slope,
                                      logic allow, logic [7:0] mstate,
                                      logic [31:0] strength, logic [31:0] fscale);
    body_t b;
    b.vx = vx; b.vy = vy; b.vz = vz; b.given = given; b.slope = slope;
    b.allow = allow; b.mstate = mstate; b.strength = strength; b.fscale = fscale;
    return b;
  endfunction

  task automatic test_extremes();
    send_body(make_body(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffffffff,
                        32'h7fffffff, 1'b1, 8'h00, 32'h7fffffff, 32'h7fffffff));
    send_body(make_body(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                        32'h80000000, 1'b1, 8'h00, 32'h80000000, 32'h80000000));
    send_body(make_body(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                        32'h80000000, 1'b1, 8'h00, 32'h7fffffff, 32'h80000000));
    send_body(make_body(0, 0, 0, 0, 0, 1'b1, 8'h00, 0, 0));
    send_body(make_body(0, 0, 0, 32'hffffffff, 32'hfffff000, 1'b1, 8'h00, 0, 0));
    send_body(make_body(32'h0000ffff, 32'hffff0000, 32'h00012345, 32'hffffffff,
                        0, 1'b1, 8'hff, 1, 256));
  endtask

  task automatic test_cases();
    // Braking disabled by the surface and by a nonzero state.
    send_body(make_body(100000, -50000, 7, 32'hffffffff, 0, 1'b0, 8'h00, 32'd400, 256));
    send_body(make_body(100000, -50000, 7, 32'hffffffff, 0, 1'b1, 8'h01, 32'd400, 256));
    send_body(make_body(100000, -50000, 7, 32'hffffffff, 0, 1'b1, 8'h80, 32'd400, 256));
    // Deceleration with the default and the scaled brake term.
    send_body(make_body(-100001, 50000, -17, 32'hffffffff, 0, 1'b1, 8'h00, 0, 256));
    send_body(make_body(-100001, 50000, -17, 32'hffffffff, 0, 1'b1, 8'h00, 32'd400, 300));
    send_body(make_body(3, -3, 1, 5000, 32'h00001000, 1'b1, 8'h00, 32'd17, -256));
    // Stop at the floor threshold, deceleration just above it, and the neither case at and below a higher threshold.
    send_body(make_body(55, -66, 77, 32'hffffffff, 32'hfffff000, 1'b1, 8'h00, 0, 256));
    send_body(make_body(55, -66, 77, 640, 32'hfffff000, 1'b1, 8'h00, 0, 256));
    send_body(make_body(55, -66, 77, 641, 32'hfffff000, 1'b1, 8'h00, 0, 256));
    send_body(make_body(55, -66, 77, 1536, 0, 1'b1, 8'h00, 0, 256));
    send_body(make_body(55, -66, 77, 32'hffffffff, 32'hfffff596, 1'b1, 8'h00, 0, 256));
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 10; i++) send_body(random_body());
    idle_input();
    while (pending_steps.size() != 0) @(posedge clk);
    for (int i = 0; i < 10; i++) send_body(random_body());
  endtask

  task automatic test_random();
    for (int i = 0; i < 950; i++) begin
      quiet = (i >= 300 && i < 450);
      send_body(random_body());
    end
    quiet = 1'b0;
    idle_input();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_cases();
    test_drain_pause();
    test_random();
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("ground_brake_velocity_step_test passed");
    end else begin
      $display("ground_brake_velocity_step_test failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("ground_brake_velocity_step_test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gbvs_pkg.sv
rtl/gbvs_sqrt.sv
rtl/ground_brake_velocity_step.sv
verif/ground_brake_velocity_step_test.sv
